[sv/rtwes_pkg.sv]
// shared types and field widths for the running two-extremes-with-sum block
// no dependencies; used by every module of the block
package rtwes_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned OutW    = 4 * SampleW + SumW + CountW;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    sample_t e1;
    sample_t e0;
  } pair_t;

  // how far the run has progressed, taken from the sample count
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_LATER  = 2'd2
  } phase_e;

  typedef struct packed {
    logic   advance;
    phase_e phase;
  } step_t;

endpackage

[sv/rtwes_pair.sv]
// one two-entry extreme pair (lowest or highest) with its insert/sort logic
// depends on rtwes_pkg
module rtwes_pair (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              lower_first_i,
  input  rtwes_pkg::step_t  step_i,
  input  rtwes_pkg::sample_t sample_i,
  output rtwes_pkg::pair_t  pair_o
);

  rtwes_pkg::pair_t pair_q, pair_d, sorted;
  logic ahead_e0, beyond_e1;

  assign ahead_e0  = lower_first_i ? (sample_i < pair_q.e0) : (sample_i > pair_q.e0);
  assign beyond_e1 = lower_first_i ? (sample_i < pair_q.e1) : (sample_i > pair_q.e1);

  always_comb begin
    if (ahead_e0) begin
      sorted.e1 = pair_q.e0;
      sorted.e0 = sample_i;
    end else begin
      sorted.e1 = sample_i;
      sorted.e0 = pair_q.e0;
    end
  end

  always_comb begin
    pair_d = pair_q;
    unique case (step_i.phase)
      rtwes_pkg::PH_FIRST:  pair_d.e0 = sample_i;
      rtwes_pkg::PH_SECOND: pair_d = sorted;
      rtwes_pkg::PH_LATER: begin
        if (beyond_e1) pair_d = sorted;
      end
      default: pair_d = pair_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
    end else if (step_i.advance) begin
      pair_q <= pair_d;
    end
  end

  assign pair_o = pair_q;

endmodule

[sv/rtwes_accum.sv]
// offset sum accumulator and saturating sample counter, plus run phase
// depends on rtwes_pkg
module rtwes_accum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  rtwes_pkg::sample_t                sample_i,
  input  rtwes_pkg::sample_t                base_i,
  output rtwes_pkg::phase_e                 phase_o,
  output logic [rtwes_pkg::SumW-1:0]        sum_o,
  output logic [rtwes_pkg::CountW-1:0]      count_o
);

  logic [rtwes_pkg::SumW-1:0]   sum_q, sum_d, diff;
  logic [rtwes_pkg::CountW-1:0] count_q, count_d;

  // sign-extend both operands before subtracting so the difference is exact
  assign diff  = rtwes_pkg::SumW'(signed'(sample_i)) - rtwes_pkg::SumW'(signed'(base_i));
  assign sum_d = sum_q + diff;
  assign count_d = (&count_q) ? count_q : count_q + 1'b1;

  always_comb begin
    priority if (count_q == '0) begin
      phase_o = rtwes_pkg::PH_FIRST;
    end else if (count_q == rtwes_pkg::CountW'(1)) begin
      phase_o = rtwes_pkg::PH_SECOND;
    end else begin
      phase_o = rtwes_pkg::PH_LATER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
    end else if (advance_i) begin
      sum_q   <= sum_d;
      count_q <= count_d;
    end
  end

  assign sum_o   = sum_q;
  assign count_o = count_q;

endmodule

[sv/running_two_extremes_with_sum_core.sv]
// top level: input register, extreme pairs, sum/count and result handshake
// depends on rtwes_pkg, rtwes_pair, rtwes_accum
//
// usage:
//   samples arrive on the s_axis stream (tdata = signed 16-bit sample) and
//   one result leaves on the m_axis stream for every sample taken.
//   a result carries the two lowest and two highest samples seen since
//   reset, the wrapping 32-bit sum of (sample - base_offset) and the sample
//   count, which saturates at 65535. second entries are meaningful once
//   the count is at least two; before that they read as stored (zero).
//   base_offset is written on the cfg channel (always ready) only while idle;
//   the user must keep to this, the block itself does not enforce it.
//   a taken sample goes through the input register, then the state/result
//   register, to m_axis. throughput: one sample per cycle unless the receiver
//   stalls, set by the combinational compare-insert and add before the state
//   registers. the state registers double as the result register; while the
//   receiver stalls the result holds and one more request waits in the
//   input register, after which s_axis_tready drops.
//   reset clears the extremes, sum, count, base_offset and both valids.
module running_two_extremes_with_sum_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] sample
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] lowest, [31:16] second_lowest, [47:32] highest,
  // [63:48] second_highest, [95:64] offset_sum, [111:96] sample_count
  output logic [rtwes_pkg::OutW-1:0]    m_axis_tdata,
  // base_offset write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [15:0]                   cfg_data_i
);

  logic               in_valid_q;
  rtwes_pkg::sample_t in_sample_q;
  rtwes_pkg::sample_t base_q;
  logic               out_valid_q;
  logic               advance;
  rtwes_pkg::step_t   step;
  rtwes_pkg::phase_e  phase;
  rtwes_pkg::pair_t   low_pair, high_pair;
  logic [rtwes_pkg::SumW-1:0]   sum;
  logic [rtwes_pkg::CountW-1:0] count;

  // state moves when a request sits in the input register and the result slot frees
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign cfg_ready_o   = 1'b1;

  assign step.advance = advance;
  assign step.phase   = phase;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) base_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) in_sample_q <= s_axis_tdata;
  end

  rtwes_pair u_low (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lower_first_i (1'b1),
    .step_i        (step),
    .sample_i      (in_sample_q),
    .pair_o        (low_pair)
  );

  rtwes_pair u_high (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .lower_first_i (1'b0),
    .step_i        (step),
    .sample_i      (in_sample_q),
    .pair_o        (high_pair)
  );

  rtwes_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .sample_i  (in_sample_q),
    .base_i    (base_q),
    .phase_o   (phase),
    .sum_o     (sum),
    .count_o   (count)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {count, sum, high_pair.e1, high_pair.e0, low_pair.e1, low_pair.e0};

endmodule
